FILE: design/tef_pkg.sv
// ----------------------------------------------------------------------------
// tef_pkg
// Shared constants, widths and the 2^(i/16) table of the force converter.
// ----------------------------------------------------------------------------
package tef_pkg;

    localparam int NUM_CHANNELS = 9;
    localparam int ADC_BITS     = 12;
    localparam int COEF_DEPTH   = NUM_CHANNELS * 4;
    localparam int ADDR_W       = $clog2(COEF_DEPTH);
    localparam int PROD_W       = 67;

    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_COFF = 2'd1;
    localparam logic [1:0] SEL_INVA = 2'd2;
    localparam logic [1:0] SEL_GAIN = 2'd3;

    localparam logic signed [32:0] LOG2E_Q24 = 33'sd24204406;

    localparam logic signed [PROD_W-1:0] EXP_MAX   = 67'sd134217727;
    localparam logic signed [PROD_W-1:0] EXP_MIN   = -67'sd134217728;
    localparam logic signed [PROD_W-1:0] FORCE_MAX = 67'sd2147483647;
    localparam logic signed [PROD_W-1:0] FORCE_MIN = -67'sd2147483648;
    localparam logic signed [36:0] TOTAL_MAX = 37'sd34359738367;
    localparam logic signed [36:0] TOTAL_MIN = -37'sd34359738368;

    function automatic logic [25:0] pow2_frac(input logic [4:0] i);
        logic [25:0] r;
        begin
            case (i)
                5'd0:    r = 26'd16777216;
                5'd1:    r = 26'd17520007;
                5'd2:    r = 26'd18295684;
                5'd3:    r = 26'd19105703;
                5'd4:    r = 26'd19951585;
                5'd5:    r = 26'd20834917;
                5'd6:    r = 26'd21757357;
                5'd7:    r = 26'd22720638;
                5'd8:    r = 26'd23726566;
                5'd9:    r = 26'd24777031;
                5'd10:   r = 26'd25874004;
                5'd11:   r = 26'd27019544;
                5'd12:   r = 26'd28215802;
                5'd13:   r = 26'd29465022;
                5'd14:   r = 26'd30769550;
                5'd15:   r = 26'd32131834;
                default: r = 26'd33554432;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: design/tef_if.sv
// ----------------------------------------------------------------------------
// tef_if
// Valid/ready channels for sample and coefficient words and force words.
// ----------------------------------------------------------------------------
interface tef_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [3:0]                    channel;
    logic [1:0]                    coef_select;
    logic signed [31:0]            coef_value;
    logic [tef_pkg::ADC_BITS-1:0]  raw_sample;

    modport source (output valid, func, channel, coef_select, coef_value, raw_sample,
                    input ready);
    modport sink   (input valid, func, channel, coef_select, coef_value, raw_sample,
                    output ready);
endinterface

interface tef_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         out_channel;
    logic signed [31:0] channel_force;
    logic signed [35:0] total_force;
    logic               total_valid;

    modport source (output valid, out_channel, channel_force, total_force, total_valid,
                    input ready);
    modport sink   (input valid, out_channel, channel_force, total_force, total_valid,
                    output ready);
endinterface

FILE: design/tef_coef_ram.sv
// ----------------------------------------------------------------------------
// tef_coef_ram
// Coefficient store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tef_coef_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [tef_pkg::ADDR_W-1:0]  waddr,
    input  logic [31:0]                 wdata,
    input  logic [tef_pkg::ADDR_W-1:0]  raddr,
    output logic [31:0]                 rdata
);

    logic [31:0] mem [tef_pkg::COEF_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/tactile_exp_force_converter.sv
// ----------------------------------------------------------------------------
// tactile_exp_force_converter
// Per-channel ADC sample to force conversion with an exponential model.
//
// in_ch carries sample words (func 0) and coefficient words (func 1).
// A coefficient word is written to the store in the cycle it is accepted.
// A sample word starts a sequence that reads the four coefficients of its
// channel from the store, one per cycle, and runs four products through one
// shared multiplier. A sample's word is loaded in the output register at the
// end of the sequence; in_ch.ready is high only while the sequencer is idle,
// so no new word is taken before that load, as the shared multiplier and the
// single store read port serve one sample at a time. Words for a channel at
// or above the channel count are taken and dropped.
// out_ch holds the result in a register; when the receiver stalls, the word
// holds and the next result waits in the sequencer until the register frees.
// Reset clears the sequencer, the output valid and the running total; the
// coefficient store holds no defined value until written.
// ----------------------------------------------------------------------------
module tactile_exp_force_converter (
    input  logic       clk,
    input  logic       rst_n,
    tef_in_if.sink     in_ch,
    tef_out_if.source  out_ch
);

    localparam int VW = tef_pkg::ADC_BITS + 26;

    typedef enum logic [3:0] {
        ST_IDLE, ST_V, ST_D, ST_M1, ST_E, ST_M2, ST_T, ST_M3, ST_G, ST_M4, ST_F, ST_OUT
    } state_t;

    state_t state_reg;

    logic [3:0]                    ch_reg;
    logic [tef_pkg::ADC_BITS-1:0]  raw_reg;
    logic signed [31:0]            v_reg;
    logic signed [32:0]            d_reg;
    logic signed [31:0]            gain_reg;
    logic signed [27:0]            e_reg;
    logic [3:0]                    idx_reg;
    logic [19:0]                   rem_reg;
    logic signed [4:0]             k_reg;
    logic [25:0]                   lo_reg;
    logic [25:0]                   m_reg;
    logic signed [31:0]            force_reg;
    logic signed [tef_pkg::PROD_W-1:0] prod_reg;
    logic signed [35:0]            total_reg;

    logic                          out_valid_reg;
    logic [3:0]                    out_channel_reg;
    logic signed [31:0]            out_force_reg;
    logic signed [35:0]            out_total_reg;
    logic                          out_tvalid_reg;

    logic                          ram_we;
    logic [tef_pkg::ADDR_W-1:0]    ram_waddr;
    logic [tef_pkg::ADDR_W-1:0]    ram_raddr;
    logic [31:0]                   ram_rdata;
    logic [1:0]                    rd_sel;

    logic                          accept;
    logic                          ch_ok;
    logic                          out_free;

    logic signed [VW-1:0]          v_ext;
    logic signed [VW-1:0]          v_sh;
    logic signed [31:0]            v_next;
    logic signed [32:0]            d_next;
    logic signed [tef_pkg::PROD_W-1:0] p_sh;
    logic signed [27:0]            e_next;
    logic signed [tef_pkg::PROD_W-1:0] t_full;
    logic [25:0]                   tab_lo;
    logic [25:0]                   tab_diff;
    logic signed [6:0]             sh_amt;
    logic signed [tef_pkg::PROD_W-1:0] f_sh;
    logic signed [31:0]            force_next;
    logic signed [36:0]            sum;
    logic signed [35:0]            total_next;
    logic signed [33:0]            mul_a;
    logic signed [32:0]            mul_b;
    logic signed [tef_pkg::PROD_W-1:0] prod_next;

    assign accept    = in_ch.valid && in_ch.ready;
    assign ch_ok     = 32'(in_ch.channel) < tef_pkg::NUM_CHANNELS;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    assign ram_we    = accept && in_ch.func && ch_ok;
    assign ram_waddr = tef_pkg::ADDR_W'({in_ch.channel, in_ch.coef_select});

    always_comb
    begin
        case (state_reg)
            ST_V:    rd_sel = tef_pkg::SEL_COFF;
            ST_D:    rd_sel = tef_pkg::SEL_INVA;
            ST_M1:   rd_sel = tef_pkg::SEL_GAIN;
            default: rd_sel = tef_pkg::SEL_ZERO;
        endcase
        if (state_reg == ST_IDLE)
        begin
            ram_raddr = tef_pkg::ADDR_W'({in_ch.channel, tef_pkg::SEL_ZERO});
        end
        else
        begin
            ram_raddr = tef_pkg::ADDR_W'({ch_reg, rd_sel});
        end
    end

    tef_coef_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_ch.coef_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        v_ext  = $signed({2'b00, raw_reg, 24'd0})
               - $signed({{(VW-32){ram_rdata[31]}}, ram_rdata});
        v_sh   = v_ext >>> tef_pkg::ADC_BITS;
        v_next = v_sh[31:0];
        d_next = {v_reg[31], v_reg} - {ram_rdata[31], ram_rdata};

        p_sh = prod_reg >>> 24;
        if (p_sh > tef_pkg::EXP_MAX)
        begin
            e_next = tef_pkg::EXP_MAX[27:0];
        end
        else if (p_sh < tef_pkg::EXP_MIN)
        begin
            e_next = tef_pkg::EXP_MIN[27:0];
        end
        else
        begin
            e_next = p_sh[27:0];
        end

        t_full   = prod_reg >>> 24;
        tab_lo   = tef_pkg::pow2_frac({1'b0, idx_reg});
        tab_diff = tef_pkg::pow2_frac({1'b0, idx_reg} + 5'd1) - tab_lo;

        sh_amt = 7'sd24 - {{2{k_reg[4]}}, k_reg};
        f_sh   = prod_reg >>> sh_amt[5:0];
        if (f_sh > tef_pkg::FORCE_MAX)
        begin
            force_next = tef_pkg::FORCE_MAX[31:0];
        end
        else if (f_sh < tef_pkg::FORCE_MIN)
        begin
            force_next = tef_pkg::FORCE_MIN[31:0];
        end
        else
        begin
            force_next = f_sh[31:0];
        end

        if (ch_reg == 4'd0)
        begin
            sum = {force_reg[31], {4{force_reg[31]}}, force_reg};
        end
        else
        begin
            sum = {total_reg[35], total_reg} + {{5{force_reg[31]}}, force_reg};
        end
        if (sum > tef_pkg::TOTAL_MAX)
        begin
            total_next = tef_pkg::TOTAL_MAX[35:0];
        end
        else if (sum < tef_pkg::TOTAL_MIN)
        begin
            total_next = tef_pkg::TOTAL_MIN[35:0];
        end
        else
        begin
            total_next = sum[35:0];
        end

        case (state_reg)
            ST_M1:
            begin
                mul_a = {d_reg[32], d_reg};
                mul_b = {ram_rdata[31], ram_rdata};
            end
            ST_M2:
            begin
                mul_a = {{6{e_reg[27]}}, e_reg};
                mul_b = tef_pkg::LOG2E_Q24;
            end
            ST_M3:
            begin
                mul_a = {8'd0, tab_diff};
                mul_b = {13'd0, rem_reg};
            end
            default:
            begin
                mul_a = {{2{gain_reg[31]}}, gain_reg};
                mul_b = {7'd0, m_reg};
            end
        endcase
        prod_next = tef_pkg::PROD_W'(mul_a * mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !in_ch.func && ch_ok)
                    begin
                        ch_reg    <= in_ch.channel;
                        raw_reg   <= in_ch.raw_sample;
                        state_reg <= ST_V;
                    end
                end
                ST_V:
                begin
                    v_reg     <= v_next;
                    state_reg <= ST_D;
                end
                ST_D:
                begin
                    d_reg     <= d_next;
                    state_reg <= ST_M1;
                end
                ST_M1:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_E;
                end
                ST_E:
                begin
                    gain_reg  <= ram_rdata;
                    e_reg     <= e_next;
                    state_reg <= ST_M2;
                end
                ST_M2:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_T;
                end
                ST_T:
                begin
                    k_reg     <= t_full[28:24];
                    idx_reg   <= t_full[23:20];
                    rem_reg   <= t_full[19:0];
                    state_reg <= ST_M3;
                end
                ST_M3:
                begin
                    prod_reg  <= prod_next;
                    lo_reg    <= tab_lo;
                    state_reg <= ST_G;
                end
                ST_G:
                begin
                    m_reg     <= lo_reg + prod_reg[45:20];
                    state_reg <= ST_M4;
                end
                ST_M4:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_F;
                end
                ST_F:
                begin
                    force_reg <= force_next;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_channel_reg <= ch_reg;
                        out_force_reg   <= force_reg;
                        out_total_reg   <= total_next;
                        out_tvalid_reg  <= (32'(ch_reg) == tef_pkg::NUM_CHANNELS - 1);
                        total_reg       <= total_next;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_channel   = out_channel_reg;
    assign out_ch.channel_force = out_force_reg;
    assign out_ch.total_force   = out_total_reg;
    assign out_ch.total_valid   = out_tvalid_reg;

endmodule

FILE: design/tef_checker.sv
// ----------------------------------------------------------------------------
// tef_checker
// Port-level checks of the force converter, bound to the top level.
// ----------------------------------------------------------------------------
module tef_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_func,
    input logic [3:0] in_channel,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] out_channel,
    input logic       total_valid
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_channel))
        else $error("output word changed while stalled");

    a_total_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (total_valid == (32'(out_channel) == tef_pkg::NUM_CHANNELS - 1)))
        else $error("total_valid does not match last channel");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_channel) < tef_pkg::NUM_CHANNELS))
        else $error("result for a channel out of range");

    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_func && (32'(in_channel) < tef_pkg::NUM_CHANNELS)
        |=> !in_ready)
        else $error("input ready while a sample is in progress");

endmodule

bind tactile_exp_force_converter tef_checker u_tef_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_func     (in_ch.func),
    .in_channel  (in_ch.channel),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_channel (out_ch.out_channel),
    .total_valid (out_ch.total_valid)
);
